/* sv/rdbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdbr_pkg
// Shared widths, register indexes, state codes and helpers for the RAID5
// degraded block read engine.
// ----------------------------------------------------------------------------
package rdbr_pkg;

    localparam int MAX_DISKS_DEF      = 16;
    localparam int WORDS_PER_DISK_DEF = 8192;

    localparam int WORD_W    = 32;
    localparam int DCNT_W    = 5;
    localparam int STRIPE_W  = 11;
    localparam int PMASK_W   = 16;
    localparam int DWORDS_W  = 14;
    localparam int BLOCK_W   = 31;
    localparam int DSEL_W    = 4;
    localparam int WOFF_W    = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int DIVS_W    = 16;
    localparam int DIV_STEPS = BLOCK_W;
    localparam int PROD_W    = BLOCK_W + STRIPE_W;
    localparam int DISK_SLOTS = 2 ** DCNT_W;

    localparam logic [CFG_IDX_W-1:0] REG_DISK_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIPE_BLOCKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISK_WORDS    = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIV1  = 9'b000000010,
        ST_DIV2  = 9'b000000100,
        ST_DIV3  = 9'b000001000,
        ST_CALC  = 9'b000010000,
        ST_CHECK = 9'b000100000,
        ST_SWEEP = 9'b001000000,
        ST_DRAIN = 9'b010000000,
        ST_FIN   = 9'b100000000
    } state_t;

    function automatic logic disk_here(input logic [PMASK_W-1:0] mask,
                                       input logic [DCNT_W-1:0] d);
        logic here;
        here = (d < DCNT_W'(PMASK_W)) && mask[d[DSEL_W-1:0]];
        return here;
    endfunction

endpackage

/* sv/raid5_degraded_block_read.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raid5_degraded_block_read
// Left-symmetric RAID5 read engine with single-disk rebuild over a word store.
//
// Words arrive on the s_ channel. A load word (s_cmd low) writes s_word_value
// into disk s_disk_select at s_word_offset and gives no result. A read word
// (s_cmd high) maps s_block_number to a disk and an offset and returns one
// result word on the m_ channel: the stored word, the XOR of the other disks
// when the data disk is the only missing one, or data_valid low and a zero
// word when the block cannot be read.
// A read runs three passes of a shared radix-2 divider (row, strip, parity
// rotation), then address and presence checks, a sweep over every disk when
// rebuilding, a drain state and an output state. An offset out of range or a
// second missing disk skips the drain; an unusable geometry skips to output.
// The store has one port, so the rebuild reads one disk per cycle.
// The engine takes the next word while a finished result waits in the output
// register; a new result waits until the receiver takes the old one.
// Reset clears control state and loads the register defaults; the store holds
// no defined contents until it is loaded. The user must write the registers
// only when idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module raid5_degraded_block_read
    import rdbr_pkg::*;
#(
    parameter int MAX_DISKS      = MAX_DISKS_DEF,
    parameter int WORDS_PER_DISK = WORDS_PER_DISK_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_DAT_W-1:0] cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_cmd,
    input  logic [DSEL_W-1:0]    s_disk_select,
    input  logic [WOFF_W-1:0]    s_word_offset,
    input  logic [WORD_W-1:0]    s_word_value,
    input  logic [BLOCK_W-1:0]   s_block_number,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_data_valid,
    output logic [WORD_W-1:0]    m_read_word
);

    localparam int DW        = $clog2(MAX_DISKS);
    localparam int WW        = $clog2(WORDS_PER_DISK);
    localparam int AW        = DW + WW;
    localparam int MEM_DEPTH = 2 ** AW;

    logic [WORD_W-1:0] mem [0:MEM_DEPTH-1];
    logic [WORD_W-1:0] rd_data_reg;

    logic [DCNT_W-1:0]   dcount_reg;
    logic [STRIPE_W-1:0] sblocks_reg;
    logic [PMASK_W-1:0]  pmask_reg;
    logic [DWORDS_W-1:0] dwords_reg;

    state_t state_reg, state_next;
    logic [DCNT_W-1:0]   n_reg, n_next;
    logic [STRIPE_W-1:0] s_reg, s_next;
    logic [BLOCK_W-1:0]  q_reg, q_next;
    logic [DIVS_W-1:0]   r_reg, r_next;
    logic [DIVS_W-1:0]   dvs_reg, dvs_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [BLOCK_W-1:0]  row_reg, row_next;
    logic [DCNT_W-1:0]   strip_reg, strip_next;
    logic [STRIPE_W-1:0] bmod_reg, bmod_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [DCNT_W-1:0]   m_reg, m_next;
    logic [DCNT_W-1:0]   ddisk_reg, ddisk_next;
    logic [WW-1:0]       w_reg, w_next;
    logic                w_ok_reg, w_ok_next;
    logic [DCNT_W-1:0]   d_reg, d_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic                dv_reg, dv_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_dv_reg, m_dv_next;
    logic [WORD_W-1:0]   m_word_reg, m_word_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    logic                accept;
    logic [DCNT_W-1:0]   n_cfg;
    logic [DIVS_W:0]     r_sh;
    logic                ge;
    logic [DIVS_W-1:0]   r_new;
    logic [BLOCK_W-1:0]  q_new;
    logic [DCNT_W-1:0]   pdisk;
    logic [DCNT_W:0]     dsum;
    logic [PROD_W:0]     wfull;
    logic                miss;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign m_valid      = m_valid_reg;
    assign m_data_valid = m_dv_reg;
    assign m_read_word  = m_word_reg;

    assign wr_en   = accept && (s_cmd == CMD_LOAD)
                     && ({28'd0, s_disk_select} < 32'(MAX_DISKS))
                     && ({19'd0, s_word_offset} < 32'(WORDS_PER_DISK));
    assign wr_addr = {DW'(s_disk_select), WW'(s_word_offset)};

    assign n_cfg = ({27'd0, dcount_reg} > 32'(MAX_DISKS)) ? DCNT_W'(MAX_DISKS)
                                                         : dcount_reg;

    assign r_sh  = {r_reg, q_reg[BLOCK_W-1]};
    assign ge    = (r_sh >= {1'b0, dvs_reg});
    assign r_new = ge ? DIVS_W'(r_sh - {1'b0, dvs_reg}) : r_sh[DIVS_W-1:0];
    assign q_new = {q_reg[BLOCK_W-2:0], ge};

    assign pdisk = n_reg - DCNT_W'(1) - m_reg;
    assign dsum  = {1'b0, pdisk} + {1'b0, strip_reg};
    assign wfull = {1'b0, prod_reg} + (PROD_W+1)'(bmod_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_word_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dcount_reg  <= DCNT_W'(2);
            sblocks_reg <= STRIPE_W'(1);
            pmask_reg   <= '0;
            dwords_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_DISK_COUNT:    dcount_reg  <= cfg_wr_data[DCNT_W-1:0];
                REG_STRIPE_BLOCKS: sblocks_reg <= cfg_wr_data[STRIPE_W-1:0];
                REG_PRESENT_MASK:  pmask_reg   <= cfg_wr_data[PMASK_W-1:0];
                REG_DISK_WORDS:    dwords_reg  <= cfg_wr_data[DWORDS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        miss = 1'b0;
        for (int i = 0; i < DISK_SLOTS; i++) begin
            if ((DCNT_W'(i) < n_reg) && (DCNT_W'(i) != ddisk_reg)
                && !disk_here(pmask_reg, DCNT_W'(i))) begin
                miss = 1'b1;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        s_next       = s_reg;
        q_next       = q_reg;
        r_next       = r_reg;
        dvs_next     = dvs_reg;
        cnt_next     = cnt_reg;
        row_next     = row_reg;
        strip_next   = strip_reg;
        bmod_next    = bmod_reg;
        prod_next    = prod_reg;
        m_next       = m_reg;
        ddisk_next   = ddisk_reg;
        w_next       = w_reg;
        w_ok_next    = w_ok_reg;
        d_next       = d_reg;
        rd_pend_next = 1'b0;
        acc_next     = rd_pend_reg ? (acc_reg ^ rd_data_reg) : acc_reg;
        dv_next      = dv_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_dv_next    = m_dv_reg;
        m_word_next  = m_word_reg;
        rd_en        = 1'b0;
        rd_addr      = {DW'(ddisk_reg), w_reg};

        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_cmd == CMD_READ)) begin
                    n_next = n_cfg;
                    s_next = sblocks_reg;
                    if ((n_cfg < DCNT_W'(2)) || (sblocks_reg == '0)) begin
                        dv_next    = 1'b0;
                        state_next = ST_FIN;
                    end else begin
                        q_next     = s_block_number;
                        r_next     = '0;
                        dvs_next   = DIVS_W'(n_cfg - DCNT_W'(1)) * DIVS_W'(sblocks_reg);
                        cnt_next   = DCNT_W'(DIV_STEPS - 1);
                        state_next = ST_DIV1;
                    end
                end
            end
            ST_DIV1: begin
                q_next   = q_new;
                r_next   = r_new;
                cnt_next = cnt_reg - DCNT_W'(1);
                if (cnt_reg == '0) begin
                    row_next   = q_new;
                    q_next     = BLOCK_W'(r_new);
                    r_next     = '0;
                    dvs_next   = DIVS_W'(s_reg);
                    cnt_next   = DCNT_W'(DIV_STEPS - 1);
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                q_next   = q_new;
                r_next   = r_new;
                cnt_next = cnt_reg - DCNT_W'(1);
                if (cnt_reg == '0) begin
                    strip_next = DCNT_W'(q_new) + DCNT_W'(1);
                    bmod_next  = STRIPE_W'(r_new);
                    prod_next  = row_reg * s_reg;
                    q_next     = row_reg;
                    r_next     = '0;
                    dvs_next   = DIVS_W'(n_reg);
                    cnt_next   = DCNT_W'(DIV_STEPS - 1);
                    state_next = ST_DIV3;
                end
            end
            ST_DIV3: begin
                q_next   = q_new;
                r_next   = r_new;
                cnt_next = cnt_reg - DCNT_W'(1);
                if (cnt_reg == '0) begin
                    m_next     = DCNT_W'(r_new);
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                ddisk_next = (dsum >= {1'b0, n_reg}) ? DCNT_W'(dsum - {1'b0, n_reg})
                                                      : DCNT_W'(dsum);
                w_ok_next  = (wfull < (PROD_W+1)'(dwords_reg))
                             && (wfull < (PROD_W+1)'(WORDS_PER_DISK));
                w_next     = WW'(wfull);
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                acc_next = '0;
                if (!w_ok_reg) begin
                    dv_next    = 1'b0;
                    state_next = ST_FIN;
                end else if (disk_here(pmask_reg, ddisk_reg)) begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    dv_next      = 1'b1;
                    state_next   = ST_DRAIN;
                end else if (miss) begin
                    dv_next    = 1'b0;
                    state_next = ST_FIN;
                end else begin
                    d_next     = '0;
                    dv_next    = 1'b1;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                rd_addr = {DW'(d_reg), w_reg};
                if (d_reg != ddisk_reg) begin
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                end
                d_next = d_reg + DCNT_W'(1);
                if (d_reg == n_reg - DCNT_W'(1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_dv_next    = dv_reg;
                    m_word_next  = dv_reg ? acc_reg : '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg     <= n_next;
        s_reg     <= s_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        dvs_reg   <= dvs_next;
        cnt_reg   <= cnt_next;
        row_reg   <= row_next;
        strip_reg <= strip_next;
        bmod_reg  <= bmod_next;
        prod_reg  <= prod_next;
        m_reg     <= m_next;
        ddisk_reg <= ddisk_next;
        w_reg     <= w_next;
        w_ok_reg  <= w_ok_next;
        d_reg     <= d_next;
        acc_reg   <= acc_next;
        dv_reg    <= dv_next;
        m_dv_reg  <= m_dv_next;
        m_word_reg <= m_word_next;
    end

endmodule
